// ===== design/tcw_pkg.sv =====
// shared types and constants for the text console writer
package tcw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int BYTE_W = 8;
  localparam int CELL_W = 2 * BYTE_W;

  localparam logic [BYTE_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0a;
  localparam logic [BYTE_W-1:0] RESET_ATTR   = 8'h0f;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_MOVE  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

endpackage

// ===== design/text_console_writer_core.sv =====
// text console writer: screen store, cursor and action sequencer
//
// Text-mode console with a COLUMNS x ROWS screen of 16-bit cells (attribute in the
// high byte, character in the low byte) held in one synchronous single-write,
// single-read memory, and a cursor kept in registers. One input beat carries one
// action: put a character at the cursor (newline moves to column 0 of the next row),
// move the cursor (coordinates taken modulo the screen size), clear the screen, or
// read one cell. Every beat gives exactly one result beat with the cursor after the
// action, the read cell (zero unless the action is a read) and a scroll flag.
// Timing: one item at a time. A put, move or read passes through accept, address
// multiply, memory access and result steps; its result is loaded into the output
// register once that register is free. A clear walks the memory one cell a cycle.
// A put that runs past the bottom row copies every row up one line through the
// memory port (one read and one write a cycle, pipelined) and then blanks the bottom
// row. After reset the block runs a clearing pass that fills the store with blanks
// in attribute 0x0f; no input beat is accepted during it, while cfg writes are
// taken at any time. The output register lets the next item be accepted while a
// result still waits.
module text_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              cfg_wr_en,
  input  logic [tcw_pkg::BYTE_W-1:0]        cfg_wr_data,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_action,
  input  logic [tcw_pkg::BYTE_W-1:0]        in_char_code,
  input  logic [tcw_pkg::BYTE_W-1:0]        in_attribute,
  input  logic [tcw_pkg::COL_W-1:0]         in_column,
  input  logic [tcw_pkg::ROW_W-1:0]         in_row,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tcw_pkg::COL_W-1:0]         out_cursor_column,
  output logic [tcw_pkg::ROW_W-1:0]         out_cursor_row,
  output logic [tcw_pkg::BYTE_W-1:0]        out_cell_char,
  output logic [tcw_pkg::BYTE_W-1:0]        out_cell_attribute,
  output logic                              out_scrolled
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int SW_W   = $clog2(CELLS + 1);
  localparam int COL_W  = tcw_pkg::COL_W;
  localparam int ROW_W  = tcw_pkg::ROW_W;
  localparam int BYTE_W = tcw_pkg::BYTE_W;
  localparam int CELL_W = tcw_pkg::CELL_W;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ADDR,
    S_EXEC,
    S_SCROLL,
    S_BLANK,
    S_DONE
  } state_t;

  // modulo tables for move/read coordinates, built at elaboration
  logic [COL_W-1:0] col_mod_tab [2**COL_W];
  logic [ROW_W-1:0] row_mod_tab [2**ROW_W];

  for (genvar g = 0; g < 2**COL_W; g++) begin : g_col_mod
    assign col_mod_tab[g] = COL_W'(g % COLUMNS);
  end
  for (genvar g = 0; g < 2**ROW_W; g++) begin : g_row_mod
    assign row_mod_tab[g] = ROW_W'(g % ROWS);
  end

  // screen store
  logic [CELL_W-1:0] screen_mem [CELLS];
  logic [CELL_W-1:0] mem_rdata_r;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= screen_mem[mem_raddr];
    end
  end

  // control and item registers
  state_t               state_r, state_nxt;
  logic [SW_W-1:0]      sweep_r, sweep_nxt;
  logic [ADDR_W-1:0]    cp_addr_r, cp_addr_nxt;
  logic                 cp_vld_r, cp_vld_nxt;
  logic [ADDR_W-1:0]    addr_r, addr_nxt;
  logic [COL_W-1:0]     cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]     cur_row_r, cur_row_nxt;
  logic [BYTE_W-1:0]    default_attr_r, default_attr_nxt;
  tcw_pkg::action_t     act_r, act_nxt;
  logic [BYTE_W-1:0]    ch_r, ch_nxt;
  logic [BYTE_W-1:0]    attr_r, attr_nxt;
  logic [COL_W-1:0]     mcol_r, mcol_nxt;
  logic [ROW_W-1:0]     mrow_r, mrow_nxt;
  logic                 scrolled_r, scrolled_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]     out_col_r, out_col_nxt;
  logic [ROW_W-1:0]     out_row_r, out_row_nxt;
  logic [BYTE_W-1:0]    out_char_r, out_char_nxt;
  logic [BYTE_W-1:0]    out_attr_r, out_attr_nxt;
  logic                 out_scr_r, out_scr_nxt;

  // cursor step helpers
  logic [COL_W:0]       col_inc;
  logic [ROW_W:0]       row_inc;
  logic [ROW_W:0]       put_row;
  logic [COL_W-1:0]     put_col;
  logic [ROW_W-1:0]     addr_row;
  logic [COL_W-1:0]     addr_col;

  assign col_inc = {1'b0, cur_col_r} + (COL_W+1)'(1);
  assign row_inc = {1'b0, cur_row_r} + (ROW_W+1)'(1);

  // cursor after a put, before the bottom-row check
  always_comb begin
    if (ch_r == tcw_pkg::NEWLINE_CHAR) begin
      put_col = '0;
      put_row = row_inc;
    end else if (col_inc == (COL_W+1)'(COLUMNS)) begin
      put_col = '0;
      put_row = row_inc;
    end else begin
      put_col = col_inc[COL_W-1:0];
      put_row = {1'b0, cur_row_r};
    end
  end

  // a read addresses the requested cell, a put the cursor
  assign addr_row = (act_r == tcw_pkg::ACT_READ) ? mrow_r : cur_row_r;
  assign addr_col = (act_r == tcw_pkg::ACT_READ) ? mcol_r : cur_col_r;

  always_comb begin
    state_nxt        = state_r;
    sweep_nxt        = sweep_r;
    cp_addr_nxt      = cp_addr_r;
    cp_vld_nxt       = cp_vld_r;
    addr_nxt         = addr_r;
    cur_col_nxt      = cur_col_r;
    cur_row_nxt      = cur_row_r;
    act_nxt          = act_r;
    ch_nxt           = ch_r;
    attr_nxt         = attr_r;
    mcol_nxt         = mcol_r;
    mrow_nxt         = mrow_r;
    scrolled_nxt     = scrolled_r;
    out_col_nxt      = out_col_r;
    out_row_nxt      = out_row_r;
    out_char_nxt     = out_char_r;
    out_attr_nxt     = out_attr_r;
    out_scr_nxt      = out_scr_r;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_waddr        = '0;
    mem_raddr        = '0;
    mem_wdata        = '0;

    default_attr_nxt = cfg_wr_en ? cfg_wr_data : default_attr_r;
    // result beat leaves when taken
    out_valid_nxt    = out_valid_r && out_stall;

    case (state_r)
      S_INIT: begin
        // power-up blanking pass
        mem_we    = 1'b1;
        mem_waddr = sweep_r[ADDR_W-1:0];
        mem_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
        if (sweep_r == SW_W'(CELLS - 1)) begin
          sweep_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          sweep_nxt = sweep_r + SW_W'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          act_nxt      = tcw_pkg::action_t'(in_action);
          ch_nxt       = in_char_code;
          attr_nxt     = in_attribute;
          mcol_nxt     = col_mod_tab[in_column];
          mrow_nxt     = row_mod_tab[in_row];
          scrolled_nxt = 1'b0;
          state_nxt    = S_ADDR;
        end
      end

      S_ADDR: begin
        addr_nxt  = ADDR_W'(ADDR_W'(addr_row) * ADDR_W'(COLUMNS) + ADDR_W'(addr_col));
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        case (act_r)
          tcw_pkg::ACT_PUT: begin
            if (ch_r != tcw_pkg::NEWLINE_CHAR) begin
              mem_we    = 1'b1;
              mem_waddr = addr_r;
              mem_wdata = {((attr_r != '0) ? attr_r : default_attr_r), ch_r};
            end
            cur_col_nxt = put_col;
            if (put_row == (ROW_W+1)'(ROWS)) begin
              // ran off the bottom: copy rows up, then blank the last one
              cur_row_nxt  = ROW_W'(ROWS - 1);
              scrolled_nxt = 1'b1;
              sweep_nxt    = SW_W'(COLUMNS);
              cp_vld_nxt   = 1'b0;
              state_nxt    = S_SCROLL;
            end else begin
              cur_row_nxt = put_row[ROW_W-1:0];
              state_nxt   = S_DONE;
            end
          end
          tcw_pkg::ACT_MOVE: begin
            cur_col_nxt = mcol_r;
            cur_row_nxt = mrow_r;
            state_nxt   = S_DONE;
          end
          tcw_pkg::ACT_CLEAR: begin
            cur_col_nxt = '0;
            cur_row_nxt = '0;
            sweep_nxt   = '0;
            state_nxt   = S_BLANK;
          end
          tcw_pkg::ACT_READ: begin
            mem_re    = 1'b1;
            mem_raddr = addr_r;
            state_nxt = S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_SCROLL: begin
        // write back the cell read last cycle one row higher
        if (cp_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = cp_addr_r;
          mem_wdata = mem_rdata_r;
        end
        if (sweep_r < SW_W'(CELLS)) begin
          mem_re      = 1'b1;
          mem_raddr   = sweep_r[ADDR_W-1:0];
          cp_addr_nxt = ADDR_W'(sweep_r - SW_W'(COLUMNS));
          cp_vld_nxt  = 1'b1;
          sweep_nxt   = sweep_r + SW_W'(1);
        end else begin
          cp_vld_nxt = 1'b0;
          sweep_nxt  = SW_W'(CELLS - COLUMNS);
          state_nxt  = S_BLANK;
        end
      end

      S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r[ADDR_W-1:0];
        mem_wdata = {default_attr_r, tcw_pkg::BLANK_CHAR};
        if (sweep_r == SW_W'(CELLS - 1)) begin
          sweep_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          sweep_nxt = sweep_r + SW_W'(1);
        end
      end

      S_DONE: begin
        // load the result once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = cur_col_r;
          out_row_nxt   = cur_row_r;
          out_scr_nxt   = scrolled_r;
          if (act_r == tcw_pkg::ACT_READ) begin
            out_char_nxt = mem_rdata_r[BYTE_W-1:0];
            out_attr_nxt = mem_rdata_r[CELL_W-1:BYTE_W];
          end else begin
            out_char_nxt = '0;
            out_attr_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_INIT;
      sweep_r        <= '0;
      cp_vld_r       <= 1'b0;
      cur_col_r      <= '0;
      cur_row_r      <= '0;
      default_attr_r <= tcw_pkg::RESET_ATTR;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      sweep_r        <= sweep_nxt;
      cp_vld_r       <= cp_vld_nxt;
      cur_col_r      <= cur_col_nxt;
      cur_row_r      <= cur_row_nxt;
      default_attr_r <= default_attr_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    cp_addr_r  <= cp_addr_nxt;
    addr_r     <= addr_nxt;
    act_r      <= act_nxt;
    ch_r       <= ch_nxt;
    attr_r     <= attr_nxt;
    mcol_r     <= mcol_nxt;
    mrow_r     <= mrow_nxt;
    scrolled_r <= scrolled_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_char_r <= out_char_nxt;
    out_attr_r <= out_attr_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_cursor_column  = out_col_r;
  assign out_cursor_row     = out_row_r;
  assign out_cell_char      = out_char_r;
  assign out_cell_attribute = out_attr_r;
  assign out_scrolled       = out_scr_r;

`ifndef SYNTH
  // cursor always inside the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cur_row_r} < (ROW_W+1)'(ROWS)) && ({1'b0, cur_col_r} < (COL_W+1)'(COLUMNS)))
    else $error("cursor outside screen");

  // a scrolled result always leaves the cursor on the bottom row
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_scr_r) |-> (out_row_r == ROW_W'(ROWS - 1)))
    else $error("scroll result not on bottom row");

  // the store is never written while waiting for an item
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("store written while idle");

  // an accepted beat closes the input until its result is formed
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat accepted during an item");
`endif

endmodule
